// ===== hw/rtl/shs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shs_pkg
// Types and constants for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } shs_in_t;

  typedef struct packed {
    logic [2:0]  word_index;
    logic [31:0] digest_word;
    logic        last_word;
  } shs_out_t;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned NUM_ROUNDS  = 64;
  localparam int unsigned NUM_WORDS   = 8;
  localparam int unsigned COUNT_W     = 61;
  localparam int unsigned LEN_W       = 64;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] INIT_HASH [NUM_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage
`default_nettype wire

// ===== hw/rtl/sha256_stream_hasher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-wide SHA-256 with in-line padding and eight-word digest output.
// ----------------------------------------------------------------------------
// A byte is taken while idle; the 64th byte of a block starts compression, 64 rounds
// on one round unit followed by the chaining add, and the input stalls until it ends.
// End of message: padding bytes fill the block, and a second block follows when
// the length spills over, each block being compressed in turn,
// then eight digest words at one per cycle when not stalled.
// Synchronous reset loads the initial hash values and clears the byte count.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
  import shs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_stall,
  input  wire shs_in_t  item,
  output logic          digest_valid,
  input  wire logic     digest_stall,
  output shs_out_t      digest
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]         state;
  logic [2:0]         ret_state;
  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] count_next;
  logic [LEN_W-1:0]   bit_len;
  logic [5:0]         pad_pos;
  logic               pad_first;
  logic               two_block;
  logic [5:0]         round;
  logic [2:0]         word_index;
  logic [511:0]       blk;
  logic [31:0]        chain [NUM_WORDS];
  logic [31:0]        va, vb, vc, vd, ve, vf, vg, vh;

  logic        item_take;
  logic        digest_take;
  logic        len_phase;
  logic [7:0]  pad_byte;
  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  assign item_take   = item_valid && !item_stall;
  assign digest_take = digest_valid && !digest_stall;
  assign item_stall  = (state != ST_IDLE);
  assign count_next  = byte_count + COUNT_W'(item.byte_valid);

  assign len_phase = (pad_pos >= LEN_POS) && !pad_first && !two_block;
  assign pad_byte  = pad_first ? PAD_BYTE : (len_phase ? bit_len[LEN_W-1 -: 8] : 8'h00);

  assign w0    = blk[511 -: 32];
  assign w1    = blk[479 -: 32];
  assign w9    = blk[223 -: 32];
  assign w14   = blk[63 -: 32];
  assign w_new = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
               + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;

  assign t1 = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25))
            + ((ve & vf) ^ (~ve & vg)) + ROUND_K[round] + w0;
  assign t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22))
            + ((va & vb) ^ (va & vc) ^ (vb & vc));

  assign digest_valid       = (state == ST_OUT);
  assign digest.word_index  = word_index;
  assign digest.digest_word = chain[word_index];
  assign digest.last_word   = (word_index == 3'(NUM_WORDS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ret_state  <= ST_IDLE;
      byte_count <= '0;
      pad_first  <= 1'b0;
      two_block  <= 1'b0;
      round      <= '0;
      word_index <= '0;
      for (int i = 0; i < NUM_WORDS; i++) chain[i] <= INIT_HASH[i];
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_take) begin
            if (item.byte_valid) begin
              blk        <= {blk[503:0], item.data_byte};
              byte_count <= count_next;
            end
            if (item.end_of_message) begin
              bit_len   <= {count_next, 3'b000};
              pad_pos   <= count_next[5:0];
              pad_first <= 1'b1;
              two_block <= (count_next[5:0] >= LEN_POS);
            end
            if (item.byte_valid && count_next[5:0] == 6'd0) begin
              {va, vb, vc, vd} <= {chain[0], chain[1], chain[2], chain[3]};
              {ve, vf, vg, vh} <= {chain[4], chain[5], chain[6], chain[7]};
              round     <= '0;
              state     <= ST_COMP;
              ret_state <= item.end_of_message ? ST_PAD : ST_IDLE;
            end else if (item.end_of_message) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          blk       <= {blk[503:0], pad_byte};
          pad_first <= 1'b0;
          pad_pos   <= pad_pos + 6'd1;
          if (len_phase) bit_len <= {bit_len[LEN_W-9:0], 8'h00};
          if (pad_pos == 6'd63) begin
            {va, vb, vc, vd} <= {chain[0], chain[1], chain[2], chain[3]};
            {ve, vf, vg, vh} <= {chain[4], chain[5], chain[6], chain[7]};
            round     <= '0;
            state     <= ST_COMP;
            ret_state <= two_block ? ST_PAD : ST_OUT;
            two_block <= 1'b0;
          end
        end
        ST_COMP: begin
          blk <= {blk[479:0], w_new};
          vh  <= vg;
          vg  <= vf;
          vf  <= ve;
          ve  <= vd + t1;
          vd  <= vc;
          vc  <= vb;
          vb  <= va;
          va  <= t1 + t2;
          round <= round + 6'd1;
          if (round == 6'(NUM_ROUNDS - 1)) state <= ST_FIN;
        end
        ST_FIN: begin
          chain[0]   <= chain[0] + va;
          chain[1]   <= chain[1] + vb;
          chain[2]   <= chain[2] + vc;
          chain[3]   <= chain[3] + vd;
          chain[4]   <= chain[4] + ve;
          chain[5]   <= chain[5] + vf;
          chain[6]   <= chain[6] + vg;
          chain[7]   <= chain[7] + vh;
          word_index <= '0;
          state      <= ret_state;
        end
        ST_OUT: begin
          if (digest_take) begin
            word_index <= word_index + 3'd1;
            if (word_index == 3'(NUM_WORDS - 1)) begin
              for (int i = 0; i < NUM_WORDS; i++) chain[i] <= INIT_HASH[i];
              byte_count <= '0;
              state      <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> item_stall)
    else $error("input taken while digest pending");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (digest_take && digest.last_word) |=> (byte_count == '0 && !digest_valid))
    else $error("state not restored after last digest word");

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMP && round == 6'(NUM_ROUNDS - 1)) |=> (state == ST_FIN))
    else $error("compression did not end after last round");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (digest_take && !digest.last_word) |=> (digest_valid && word_index == $past(word_index) + 3'd1))
    else $error("digest words out of order");

endmodule
`default_nettype wire

// ===== tb/sv/sha256_stream_hasher_tb.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Drives random and hand-picked byte streams into the hasher with random
// gaps on the input side and random stalls on the digest side. A SHA-256
// predictor in the bench tracks every accepted word. Each digest word is
// checked field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;
  import shs_pkg::*;

  localparam int TOTAL_WORDS    = 270;
  localparam int TAIL_WORDS     = 40;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_stall;
  shs_in_t  item = '0;
  logic     digest_valid;
  logic     digest_stall = 1'b0;
  shs_out_t digest;

  shs_in_t  msg_word_q[$];
  shs_out_t digest_word_q[$];
  shs_out_t digest_want;

  logic [31:0] chain_q [NUM_WORDS];
  logic [7:0]  blk_q [BLOCK_BYTES];
  logic [60:0] count_q;

  int msg_words;
  int words_total;
  int words_taken;
  int errors;
  int idle_cycles;
  int send_idle, send_phase, send_gap_pct;
  int recv_idle, recv_phase, recv_gap_pct;

  sha256_stream_hasher u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] rotr32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_reset();
    for (int i = 0; i < NUM_WORDS; i++) chain_q[i] = INIT_HASH[i];
    count_q = '0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [NUM_ROUNDS];
    logic [31:0] v [NUM_WORDS];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_q[4*i], blk_q[4*i+1], blk_q[4*i+2], blk_q[4*i+3]};
    for (int i = 16; i < NUM_ROUNDS; i++) begin
      s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < NUM_WORDS; i++) v[i] = chain_q[i];
    for (int i = 0; i < NUM_ROUNDS; i++) begin
      t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < NUM_WORDS; i++) chain_q[i] = chain_q[i] + v[i];
  endfunction

  // absorb one accepted word, queue the digest on end of message
  function automatic void sha_take_word(shs_in_t w);
    logic [5:0]  pos;
    logic [63:0] bit_len;
    shs_out_t    r;
    if (w.byte_valid) begin
      blk_q[count_q[5:0]] = w.data_byte;
      count_q = count_q + 1'b1;
      if (count_q[5:0] == 6'd0) sha_compress();
    end
    if (w.end_of_message) begin
      pos = count_q[5:0];
      blk_q[pos] = PAD_BYTE;
      for (int i = pos + 1; i < BLOCK_BYTES; i++) blk_q[i] = 8'h00;
      if (pos >= LEN_POS) begin
        sha_compress();
        for (int i = 0; i < LEN_POS; i++) blk_q[i] = 8'h00;
      end
      bit_len = {count_q, 3'b000};
      for (int i = 0; i < 8; i++) blk_q[BLOCK_BYTES - 1 - i] = bit_len[8*i +: 8];
      sha_compress();
      for (int i = 0; i < NUM_WORDS; i++) begin
        r.word_index  = i[2:0];
        r.digest_word = chain_q[i];
        r.last_word   = (i == NUM_WORDS - 1);
        digest_word_q.push_back(r);
      end
      sha_reset();
    end
  endfunction

  function automatic int gap_pct_pick();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  task automatic queue_word(logic [7:0] d, logic bv, logic eom);
    shs_in_t w;
    w.data_byte      = d;
    w.byte_valid     = bv;
    w.end_of_message = eom;
    msg_word_q.push_back(w);
    if (bv || eom) msg_words++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      sha_reset();
    end else if (!item_valid || !item_stall) begin
      if (item_valid) begin
        sha_take_word(item);
        words_taken++;
      end
      if (send_phase == 0) begin
        send_phase   = $urandom_range(20, 120);
        send_gap_pct = gap_pct_pick();
      end else begin
        send_phase--;
      end
      if (send_idle > 0) begin
        send_idle--;
        item_valid <= 1'b0;
      end else if (msg_word_q.size() == 0) begin
        item_valid <= 1'b0;
      end else if (msg_word_q.size() > TAIL_WORDS && $urandom_range(0, 99) < send_gap_pct) begin
        send_idle = $urandom_range(0, 8);
        item_valid <= 1'b0;
      end else begin
        item       <= msg_word_q.pop_front();
        item_valid <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      digest_stall <= 1'b0;
    end else begin
      if (digest_valid && !digest_stall) begin
        if (digest_word_q.size() == 0) begin
          $display("%0t: unexpected digest word: expected none, got %h", $time, digest);
          errors++;
        end else begin
          digest_want = digest_word_q.pop_front();
          check_field("word_index", 32'(digest_want.word_index), 32'(digest.word_index));
          check_field("digest_word", digest_want.digest_word, digest.digest_word);
          check_field("last_word", 32'(digest_want.last_word), 32'(digest.last_word));
        end
      end
      if (recv_phase == 0) begin
        recv_phase   = $urandom_range(20, 120);
        recv_gap_pct = gap_pct_pick();
      end else begin
        recv_phase--;
      end
      if (recv_idle > 0) begin
        recv_idle--;
        digest_stall <= 1'b1;
      end else if (msg_word_q.size() > TAIL_WORDS && $urandom_range(0, 99) < recv_gap_pct) begin
        recv_idle = $urandom_range(0, 8);
        digest_stall <= 1'b1;
      end else begin
        digest_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (digest_valid && !digest_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sha256_stream_hasher verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int len;
    bit split_end;
    int first_len [3];
    int len_pool [8];
    first_len = '{55, 56, 64};
    len_pool  = '{0, 1, 55, 56, 63, 64, 65, 120};

    // empty message, data ignored without byte_valid
    queue_word(8'h00, 1'b0, 1'b1);
    queue_word(8'hff, 1'b0, 1'b0);
    queue_word(8'hff, 1'b0, 1'b1);
    // last byte with end mark
    queue_word(8'h61, 1'b1, 1'b0);
    queue_word(8'h62, 1'b1, 1'b0);
    queue_word(8'h63, 1'b1, 1'b1);
    // extreme bytes, empty word inside, separate end mark
    queue_word(8'h00, 1'b1, 1'b0);
    queue_word(8'ha5, 1'b0, 1'b0);
    queue_word(8'hff, 1'b1, 1'b0);
    queue_word(8'h80, 1'b1, 1'b0);
    queue_word(8'h5a, 1'b0, 1'b1);
    queue_word(8'hff, 1'b1, 1'b1);

    for (int m = 0; msg_words < TOTAL_WORDS; m++) begin
      if (m < 3) len = first_len[m];
      else if ($urandom_range(0, 3) == 0) len = len_pool[$urandom_range(0, 7)];
      else len = $urandom_range(0, 40);
      split_end = (len == 0) || ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        queue_word(8'($urandom_range(0, 255)), 1'b1, !split_end && i == len - 1);
      end
      if (split_end) queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    words_total = msg_word_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (words_taken < words_total) @(negedge clk);
    while (digest_word_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("sha256_stream_hasher verification clean");
    end else begin
      $display("sha256_stream_hasher verification failed");
    end
    $finish;
  end

endmodule
